/* rtl/sbt_pkg.sv */
// Package for the software breakpoint table: request and response beat types,
// request codes, state machine encoding and fixed field widths.
// No dependencies.
package sbt_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 16;

  localparam logic [1:0] REQ_SET    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FILTER = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } sbt_state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] mem_word;
  } sbt_req_t;

  typedef struct packed {
    logic              ok;
    logic              mem_write;
    logic [DATA_W-1:0] result_word;
  } sbt_rsp_t;

endpackage

/* rtl/sbt_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module sbt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/software_breakpoint_table_unit.sv */
// Software breakpoint table: top level with slot scan, set/remove/filter logic.
// Depends on sbt_pkg and sbt_ram.
//
// A rejected request (zero address on set or remove, unknown code) goes
// straight to the done state; other requests read the slots one per cycle
// through the RAM read port, set and remove stopping at the first hit and a
// filter reading every slot. A new beat is taken only after the last result
// has been put in the output register. After reset a clearing pass zeroes the
// address RAM while input ready stays low; configuration writes are taken always.
module software_breakpoint_table_unit
  import sbt_pkg::*;
#(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned WORD_BYTES  = 4,
  parameter int unsigned BREAK_BYTES = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sbt_req_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sbt_rsp_t         out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // Internal word width follows WORD_BYTES; the port word is zero-extended or
  // truncated to it, and the result is cut back to the port width.
  localparam int unsigned WORD_W   = 8 * WORD_BYTES;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);
  // Only pattern bytes that fall inside the word take part.
  localparam int unsigned OV_BYTES = (BREAK_BYTES < WORD_BYTES) ? BREAK_BYTES : WORD_BYTES;

  sbt_state_e         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rv_q;
  logic [IDX_W-1:0]   rv_idx_q;
  logic [1:0]         req_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [WORD_W-1:0]  word_q;
  logic [WORD_W-1:0]  acc_q, acc_d;
  logic               ok_q, ok_d;
  logic               wr_q, wr_d;
  logic [CFG_W-1:0]   pattern_q;
  logic               out_valid_q;
  sbt_rsp_t           out_q;

  logic               in_fire;
  logic               req_bad;
  logic               issue;
  logic               hit;
  logic               last;
  logic               slot_busy;
  logic               out_free;
  logic               out_load;
  logic [WORD_W-1:0]  word_in;
  logic [WORD_W-1:0]  set_word;
  logic [WORD_W-1:0]  filt_word;
  logic signed [ADDR_W+1:0] slot_dist;
  logic [31:0]        pat_wide;

  logic               addr_we;
  logic [IDX_W-1:0]   addr_waddr;
  logic [ADDR_W-1:0]  addr_wdata;
  logic [ADDR_W-1:0]  slot_addr_rd;
  logic               orig_we;
  logic [WORD_W-1:0]  slot_orig_rd;

  // Two memories: slot addresses (cleared after reset) and the original
  // words (only ever used for slots whose address is set).
  sbt_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (ENTRIES)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (addr_we),
    .waddr_i (addr_waddr),
    .wdata_i (addr_wdata),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (slot_addr_rd)
  );

  sbt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (orig_we),
    .waddr_i (rv_idx_q),
    .wdata_i (word_q),
    .raddr_i (cnt_q[IDX_W-1:0]),
    .rdata_o (slot_orig_rd)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_load    = (state_q == ST_DONE) && out_free;

  assign word_in = WORD_W'({{WORD_W{1'b0}}, in_data_i.mem_word});

  // Requests that finish without touching the table.
  assign req_bad = (in_data_i.req_type != REQ_SET && in_data_i.req_type != REQ_REMOVE &&
                    in_data_i.req_type != REQ_FILTER) ||
                   (in_data_i.req_type != REQ_FILTER && in_data_i.addr == '0);

  // Reads go out one slot per cycle; the registered read data belongs to slot rv_idx_q.
  assign issue     = (state_q == ST_SCAN) && (cnt_q != CNT_W'(ENTRIES));
  assign slot_busy = (slot_addr_rd != '0);
  assign last      = rv_q && (rv_idx_q == IDX_W'(ENTRIES - 1));
  assign hit       = rv_q && (((req_q == REQ_SET) && !slot_busy) ||
                              ((req_q == REQ_REMOVE) && (slot_addr_rd == addr_q)));

  // Break pattern bytes are right-aligned in the register, big-endian.
  assign pat_wide = {{(32 - CFG_W){1'b0}}, pattern_q};

  always_comb begin
    set_word = word_q;
    for (int j = 0; j < OV_BYTES; j++) begin
      set_word[8*(WORD_BYTES-1-j) +: 8] = pat_wide[8*(BREAK_BYTES-1-j) +: 8];
    end
  end

  // Byte j of a breakpoint lands at word byte k when the slot address minus
  // the read address equals k - j. The difference is taken two bits wider so
  // that ranges near the top of the address space compare without wrapping.
  always_comb begin
    filt_word = acc_q;
    slot_dist = $signed({2'b00, slot_addr_rd}) - $signed({2'b00, addr_q});
    for (int j = 0; j < OV_BYTES; j++) begin
      for (int k = 0; k < WORD_BYTES; k++) begin
        if (slot_dist == (ADDR_W + 2)'(k - j)) begin
          filt_word[8*(WORD_BYTES-1-k) +: 8] = slot_orig_rd[8*(WORD_BYTES-1-j) +: 8];
        end
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (cnt_q[IDX_W-1:0] == IDX_W'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = req_bad ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    cnt_d      = cnt_q;
    acc_d      = acc_q;
    ok_d       = ok_q;
    wr_d       = wr_q;
    addr_we    = 1'b0;
    addr_waddr = rv_idx_q;
    addr_wdata = '0;
    orig_we    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        addr_we    = 1'b1;
        addr_waddr = cnt_q[IDX_W-1:0];
        if (cnt_q[IDX_W-1:0] == IDX_W'(ENTRIES - 1)) begin
          cnt_d = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          cnt_d = '0;
          wr_d  = 1'b0;
          // A filter always succeeds; set and remove succeed only on a hit.
          ok_d  = !req_bad && (in_data_i.req_type == REQ_FILTER);
          acc_d = ok_d ? word_in : '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rv_q) begin
          case (req_q)
            REQ_SET: begin
              if (hit) begin
                acc_d      = set_word;
                ok_d       = 1'b1;
                wr_d       = 1'b1;
                addr_we    = 1'b1;
                addr_wdata = addr_q;
                orig_we    = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (hit) begin
                acc_d   = slot_orig_rd;
                ok_d    = 1'b1;
                wr_d    = 1'b1;
                addr_we = 1'b1;
              end
            end
            REQ_FILTER: begin
              if (slot_busy) begin
                acc_d = filt_word;
              end
            end
            default: acc_d = '0;
          endcase
        end
      end
      ST_DONE: begin
        cnt_d = '0;
      end
      default: cnt_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      pattern_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= issue && !(hit || last);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pattern_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rv_idx_q <= cnt_q[IDX_W-1:0];
    acc_q    <= acc_d;
    ok_q     <= ok_d;
    wr_q     <= wr_d;
    if (in_fire) begin
      req_q  <= in_data_i.req_type;
      addr_q <= in_data_i.addr;
      word_q <= word_in;
    end
    if (out_load) begin
      out_q.ok          <= ok_q;
      out_q.mem_write   <= wr_q;
      out_q.result_word <= DATA_W'({{DATA_W{1'b0}}, acc_q});
    end
  end

endmodule

/* rtl/sbt_checker.sv */
// Port-level checker for the software breakpoint table, with its bind.
// Depends on sbt_pkg and binds to software_breakpoint_table_unit.
module sbt_checker
  import sbt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input sbt_rsp_t out_data_i
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat changed while stalled");

  // Only a successful request asks for a memory write.
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.mem_write |-> out_data_i.ok)
    else $error("memory write without success");

  // Every failure returns a zero word.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.ok |-> out_data_i.result_word == '0)
    else $error("failed request returned a nonzero word");

  // One request at a time: the input closes right after a beat is taken.
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready directly after an accepted beat");

endmodule

bind software_breakpoint_table_unit sbt_checker u_sbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);

/* test/tb_software_breakpoint_table_unit.sv */
// Self-checking testbench for software_breakpoint_table_unit: directed and random
// set/remove/filter beats checked against a shadow breakpoint table.
// Depends on sbt_pkg and the RTL of software_breakpoint_table_unit.
`timescale 1ns / 100ps

module tb_software_breakpoint_table_unit;
  import sbt_pkg::*;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned WORD_BYTES  = 4;
  localparam int unsigned BREAK_BYTES = 2;

  // Code 3 is not a request the block knows; it must answer with all zeros.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Length of the long output back-pressure stretch, in cycles.
  localparam int LONG_HOLD = 400;
  // Upper bound on the wait for outstanding responses at a phase boundary.
  localparam int DRAIN_LIMIT = 20000;
  // Items in each random phase.
  localparam int PHASE_ITEMS = 390;

  // Shadow of the breakpoint table. It is updated at the moment a request beat
  // is accepted and queues the response that beat must produce; responses are
  // compared in order against that queue.
  class bkpt_shadow;
    logic [CFG_W-1:0]  pattern;
    logic [ADDR_W-1:0] slot_addr [ENTRIES];
    logic [DATA_W-1:0] slot_orig [ENTRIES];
    sbt_rsp_t          owed_rsp[$];
    int                errors;

    function new();
      pattern = '0;
      errors  = 0;
      foreach (slot_addr[i]) begin
        slot_addr[i] = '0;
        slot_orig[i] = '0;
      end
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (slot_addr[i]) begin
        if (slot_addr[i] != '0) n++;
      end
      return n;
    endfunction

    // A randomly chosen address that currently holds a breakpoint, or zero.
    function logic [ADDR_W-1:0] any_stored();
      int idx[$];
      foreach (slot_addr[i]) begin
        if (slot_addr[i] != '0) idx.push_back(i);
      end
      if (idx.size() == 0) return '0;
      return slot_addr[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    // The word to write back on a set: break bytes over the leading bytes.
    function logic [DATA_W-1:0] lay_pattern(logic [DATA_W-1:0] w);
      logic [DATA_W-1:0] r;
      r = w;
      for (int j = 0; j < BREAK_BYTES && j < WORD_BYTES; j++) begin
        r[8*(WORD_BYTES-1-j) +: 8] = pattern[8*(BREAK_BYTES-1-j) +: 8];
      end
      return r;
    endfunction

    // The read word with original bytes put back under every breakpoint that
    // overlaps it. Sums are one bit wider than the address so nothing wraps.
    function logic [DATA_W-1:0] restore_word(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] w);
      logic [ADDR_W:0]   lo;
      logic [ADDR_W:0]   hi;
      logic [ADDR_W:0]   b;
      logic [DATA_W-1:0] r;
      int                k;
      r  = w;
      lo = {1'b0, a};
      hi = lo + WORD_BYTES;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_addr[i] == '0) continue;
        for (int j = 0; j < BREAK_BYTES && j < WORD_BYTES; j++) begin
          b = {1'b0, slot_addr[i]} + j;
          if (b >= lo && b < hi) begin
            k = int'(b - lo);
            r[8*(WORD_BYTES-1-k) +: 8] = slot_orig[i][8*(WORD_BYTES-1-j) +: 8];
          end
        end
      end
      return r;
    endfunction

    function void note_request(sbt_req_t req);
      sbt_rsp_t rsp;
      int       hit;
      rsp = '0;
      hit = -1;
      case (req.req_type)
        REQ_SET: begin
          if (req.addr != '0) begin
            for (int i = 0; i < ENTRIES && hit < 0; i++) begin
              if (slot_addr[i] == '0) hit = i;
            end
            if (hit >= 0) begin
              slot_addr[hit]  = req.addr;
              slot_orig[hit]  = req.mem_word;
              rsp.ok          = 1'b1;
              rsp.mem_write   = 1'b1;
              rsp.result_word = lay_pattern(req.mem_word);
            end
          end
        end
        REQ_REMOVE: begin
          if (req.addr != '0) begin
            for (int i = 0; i < ENTRIES && hit < 0; i++) begin
              if (slot_addr[i] == req.addr) hit = i;
            end
            if (hit >= 0) begin
              rsp.ok          = 1'b1;
              rsp.mem_write   = 1'b1;
              rsp.result_word = slot_orig[hit];
              slot_addr[hit]  = '0;
            end
          end
        end
        REQ_FILTER: begin
          rsp.ok          = 1'b1;
          rsp.result_word = restore_word(req.addr, req.mem_word);
        end
        default: begin
        end
      endcase
      owed_rsp.push_back(rsp);
    endfunction

    function void check_response(sbt_rsp_t got);
      sbt_rsp_t want;
      if (owed_rsp.size() == 0) begin
        $error("response beat with nothing outstanding: ok=%0b mem_write=%0b result_word=%08h",
               got.ok, got.mem_write, got.result_word);
        errors++;
        return;
      end
      want = owed_rsp.pop_front();
      if (got.ok !== want.ok) begin
        $error("ok: expected %0b, got %0b", want.ok, got.ok);
        errors++;
      end
      if (got.mem_write !== want.mem_write) begin
        $error("mem_write: expected %0b, got %0b", want.mem_write, got.mem_write);
        errors++;
      end
      if (got.result_word !== want.result_word) begin
        $error("result_word: expected %08h, got %08h", want.result_word, got.result_word);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  sbt_req_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  sbt_rsp_t         out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  bkpt_shadow sb;

  // Idle controls shared between the stimulus and the response side. The
  // stimulus sets them per phase; the long hold request is consumed by the
  // response side, which counts the stretch itself.
  bit tx_idle_en    = 1'b0;
  bit rx_idle_en    = 1'b0;
  bit long_hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  software_breakpoint_table_unit #(
    .ENTRIES    (ENTRIES),
    .WORD_BYTES (WORD_BYTES),
    .BREAK_BYTES(BREAK_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // The tasks below that offer a beat are entered just after a rising edge and leave
  // just after the edge at which their beat was taken. Handshake signals are sampled in
  // that step, so they still hold the values that the edge itself saw.

  // Offer one request beat, optionally after a short idle burst, and hand it
  // to the shadow table once it is accepted. Valid stays high afterwards so
  // that back-to-back beats need no second assignment in the same step.
  task automatic send_request(input sbt_req_t req);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  // Write the break pattern register; only called while no request is outstanding.
  task automatic write_pattern(input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.pattern = value;
  endtask

  // Stop offering beats and wait until every owed response has come back or the
  // drain limit runs out, then keep waiting so that a stray beat would show.
  task automatic drain_responses();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.owed_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (ENTRIES + 8) @(posedge clk_i);
  endtask

  function automatic sbt_req_t mk_req(logic [1:0] kind, logic [ADDR_W-1:0] a,
                                      logic [DATA_W-1:0] w);
    sbt_req_t req;
    req.req_type = kind;
    req.addr     = a;
    req.mem_word = w;
    return req;
  endfunction

  // Addresses are drawn mostly from a dense window so that duplicates,
  // overlapping breakpoints and filter hits are common, some from the very top
  // of the address space, and a few from anywhere.
  function automatic logic [ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
      1:       return $urandom;
      default: return 32'h0000_1000 + 32'($urandom_range(0, 47));
    endcase
  endfunction

  // One random request. While filling, sets dominate so the table reaches
  // full; while draining, removes of stored addresses dominate. A small share
  // is noise: unknown codes, zero addresses, removes that miss, wild filters.
  function automatic sbt_req_t random_request(input bit filling);
    logic [ADDR_W-1:0] a;
    int                r;
    r = $urandom_range(0, 99);
    if (r < (filling ? 55 : 20)) begin
      return mk_req(REQ_SET, pick_addr(), $urandom);
    end
    if (r < (filling ? 70 : 60)) begin
      a = sb.any_stored();
      if (a == '0) a = pick_addr();
      return mk_req(REQ_REMOVE, a, $urandom);
    end
    if (r < (filling ? 92 : 88)) begin
      a = sb.any_stored();
      if (a == '0 || $urandom_range(0, 3) == 0) a = pick_addr();
      // Start the read word from three bytes before the breakpoint to one byte after
      // it so that every partial overlap occurs.
      a = a + 32'($urandom_range(0, 4)) - 32'd3;
      return mk_req(REQ_FILTER, a, $urandom);
    end
    case ($urandom_range(0, 3))
      0:       return mk_req(REQ_UNKNOWN, $urandom, $urandom);
      1:       return mk_req(REQ_SET, '0, $urandom);
      2:       return mk_req(REQ_REMOVE, ($urandom_range(0, 1) != 0) ? '0 : $urandom, $urandom);
      default: return mk_req(REQ_FILTER, $urandom, $urandom);
    endcase
  endfunction

  task automatic run_random(input int count, input int hold_at);
    bit filling;
    filling = 1'b1;
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) long_hold_req = 1'b1;
      // Linger at full for a while so set-on-full happens repeatedly, then
      // drain down to nearly empty before filling again.
      if (filling && sb.occupancy() == ENTRIES && $urandom_range(0, 7) == 0) begin
        filling = 1'b0;
      end else if (!filling && sb.occupancy() < 3) begin
        filling = 1'b1;
      end
      send_request(random_request(filling));
    end
  endtask

  // Directed beats: rejected and unknown requests, duplicates, first-match
  // removal, overlapping filters where a later slot wins, and breakpoints at
  // the top of the address space where the read window must not wrap.
  task automatic run_directed();
    send_request(mk_req(REQ_SET,     32'h0000_0000, 32'h1234_5678));
    send_request(mk_req(REQ_REMOVE,  32'h0000_0000, 32'h0000_0000));
    send_request(mk_req(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(mk_req(REQ_FILTER,  32'h0000_0000, 32'h1234_5678));
    send_request(mk_req(REQ_SET,     32'h0000_1000, 32'h1122_3344));
    send_request(mk_req(REQ_SET,     32'h0000_1000, 32'h5566_7788));
    send_request(mk_req(REQ_SET,     32'h0000_1002, 32'h99AA_BBCC));
    send_request(mk_req(REQ_FILTER,  32'h0000_1000, 32'hDEAD_BEEF));
    send_request(mk_req(REQ_FILTER,  32'h0000_0FFE, 32'h0000_0000));
    send_request(mk_req(REQ_FILTER,  32'h0000_1003, 32'hFFFF_FFFF));
    send_request(mk_req(REQ_SET,     32'hFFFF_FFFF, 32'hCAFE_F00D));
    send_request(mk_req(REQ_SET,     32'hFFFF_FFFE, 32'h0BAD_C0DE));
    send_request(mk_req(REQ_FILTER,  32'hFFFF_FFFE, 32'h0000_0000));
    send_request(mk_req(REQ_FILTER,  32'hFFFF_FFFC, 32'hA5A5_A5A5));
    send_request(mk_req(REQ_FILTER,  32'h0000_0000, 32'hFFFF_FFFF));
    send_request(mk_req(REQ_REMOVE,  32'h0000_1000, 32'h0000_0000));
    send_request(mk_req(REQ_REMOVE,  32'h0000_1234, 32'h0000_0000));
    send_request(mk_req(REQ_REMOVE,  32'h0000_1000, 32'h0000_0000));
    send_request(mk_req(REQ_REMOVE,  32'h0000_1000, 32'h0000_0000));
    send_request(mk_req(REQ_SET,     32'h0000_2000, 32'h0000_0000));
    send_request(mk_req(REQ_REMOVE,  32'hFFFF_FFFF, 32'h0000_0000));
    send_request(mk_req(REQ_FILTER,  32'h0000_1001, 32'h0F0F_0F0F));
    send_request(mk_req(REQ_SET,     32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  // Response side: checks every accepted beat and randomizes ready. A long
  // hold, when requested, keeps ready low for the whole long stretch while
  // the stimulus keeps offering beats, so the block backs up into its input.
  initial begin : rsp_side
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_response(out_data_o);
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD - 1;
        out_ready_i  <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left   = $urandom_range(0, 4);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Main sequence. Each phase ends by draining all owed responses, which is
  // also where the pattern register is rewritten; the last phase runs with no
  // idling on either side.
  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_pattern(16'hA5C3);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    run_directed();
    drain_responses();

    write_pattern(16'h0000);
    run_random(PHASE_ITEMS, -1);
    drain_responses();

    write_pattern(16'hFFFF);
    run_random(PHASE_ITEMS, 100);
    drain_responses();

    write_pattern(CFG_W'($urandom));
    run_random(PHASE_ITEMS, -1);
    drain_responses();

    write_pattern(16'h4E71);
    run_random(PHASE_ITEMS, -1);
    drain_responses();

    write_pattern(CFG_W'($urandom));
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(PHASE_ITEMS, -1);
    drain_responses();

    if (sb.owed_rsp.size() != 0) begin
      $error("%0d response beats never arrived", sb.owed_rsp.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a time limit several times the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
rtl/sbt_pkg.sv
rtl/sbt_ram.sv
rtl/software_breakpoint_table_unit.sv
rtl/sbt_checker.sv
test/tb_software_breakpoint_table_unit.sv
